### rtl/sipq_pkg.sv
package sipq_pkg;

    localparam int PAY_W = 32;
    localparam int PRI_W = 16;
    localparam int POS_W = 4;
    localparam int CNT_W = 5;
    localparam int ST_W  = 2;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_READ   = 1'b1;

    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
    localparam logic [ST_W-1:0] ST_RANGE = 2'd2;

    typedef struct packed {
        logic signed [PRI_W-1:0] pri;
        logic [PAY_W-1:0]        payload;
    } t_entry;

    typedef struct packed {
        logic [PAY_W-1:0]        read_payload;
        logic signed [PRI_W-1:0] read_priority;
        logic [CNT_W-1:0]        entry_count;
        logic [ST_W-1:0]         status;
    } t_result;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RWAIT,
        S_SCAN,
        S_PUT,
        S_DONE
    } t_state;

endpackage

### rtl/sipq_if.sv
interface sipq_in_if;
    import sipq_pkg::*;
    logic                    valid;
    logic                    ready;
    logic                    opcode;
    logic [PAY_W-1:0]        payload;
    logic signed [PRI_W-1:0] priority_req;
    logic [POS_W-1:0]        position;

    modport source (output valid, output opcode, output payload, output priority_req,
                    output position, input ready);
    modport sink   (input valid, input opcode, input payload, input priority_req,
                    input position, output ready);
endinterface

interface sipq_out_if;
    import sipq_pkg::*;
    logic                    valid;
    logic                    ready;
    logic [PAY_W-1:0]        read_payload;
    logic signed [PRI_W-1:0] read_priority;
    logic [CNT_W-1:0]        entry_count;
    logic [ST_W-1:0]         status;

    modport source (output valid, output read_payload, output read_priority,
                    output entry_count, output status, input ready);
    modport sink   (input valid, input read_payload, input read_priority,
                    input entry_count, input status, output ready);
endinterface

### rtl/sorted_insert_priority_queue.sv
// Bounded priority queue held in ascending priority order in one synchronous
// RAM of CAPACITY entries (priority and payload). An insert walks the stored
// entries from the tail toward the head, moving each entry whose priority is
// not lower than the new one up one slot, then writes the new entry into the
// gap, so it lands ahead of equal priorities. One RAM read and one RAM write
// per cycle set the pace; an insert into an empty or full queue needs no scan,
// a read makes one RAM access, an out-of-range read none. One item is in
// work at a time; the result sits in an output register, so the next item
// is taken while it waits. The RAM needs no clearing after reset, only entries
// below the count are read.
module sorted_insert_priority_queue #(
    parameter int CAPACITY = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    sipq_in_if.sink    i_req,
    sipq_out_if.source o_res
);
    import sipq_pkg::*;

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    logic    res_valid;
    logic    res_ready;
    t_result res;
    logic    wr_en;
    logic    rd_en;
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] rd_addr;
    t_entry  wr_data;
    t_entry  rd_data;

    logic    r_out_valid;
    t_result r_out;

    sipq_ctrl #(
        .CAPACITY (CAPACITY),
        .AW       (AW),
        .CW       (CW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res       (res),
        .o_wr_en     (wr_en),
        .o_wr_addr   (wr_addr),
        .o_wr_data   (wr_data),
        .o_rd_en     (rd_en),
        .o_rd_addr   (rd_addr),
        .i_rd_data   (rd_data)
    );

    sipq_mem #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // load the output register when it is empty or being drained
    assign res_ready = !r_out_valid || o_res.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_ready) begin
            r_out_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_ready && res_valid) begin
            r_out <= res;
        end
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.read_payload  = r_out.read_payload;
    assign o_res.read_priority = r_out.read_priority;
    assign o_res.entry_count   = r_out.entry_count;
    assign o_res.status        = r_out.status;

endmodule

### rtl/sipq_mem.sv
module sipq_mem #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic                 i_clk,
    input  logic                 i_wr_en,
    input  logic [AW-1:0]        i_wr_addr,
    input  sipq_pkg::t_entry     i_wr_data,
    input  logic                 i_rd_en,
    input  logic [AW-1:0]        i_rd_addr,
    output sipq_pkg::t_entry     o_rd_data
);
    import sipq_pkg::*;

    t_entry r_mem [DEPTH];
    t_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### rtl/sipq_ctrl.sv
module sipq_ctrl #(
    parameter int CAPACITY = 16,
    parameter int AW       = 4,
    parameter int CW       = 5
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    sipq_in_if.sink           i_req,
    output logic              o_res_valid,
    input  logic              i_res_ready,
    output sipq_pkg::t_result o_res,
    output logic              o_wr_en,
    output logic [AW-1:0]     o_wr_addr,
    output sipq_pkg::t_entry  o_wr_data,
    output logic              o_rd_en,
    output logic [AW-1:0]     o_rd_addr,
    input  sipq_pkg::t_entry  i_rd_data
);
    import sipq_pkg::*;

    t_state        r_state, n_state;
    logic [AW-1:0] r_k, n_k;
    logic [CW-1:0] r_count, n_count;
    t_entry        r_new, n_new;
    t_result       r_res, n_res;
    logic [CW-1:0] count_inc;

    assign count_inc = CW'(r_count + 1'b1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_k   <= n_k;
        r_new <= n_new;
        r_res <= n_res;
    end

    always_comb begin
        n_state     = r_state;
        n_k         = r_k;
        n_count     = r_count;
        n_new       = r_new;
        n_res       = r_res;
        o_wr_en     = 1'b0;
        o_wr_addr   = '0;
        o_wr_data   = r_new;
        o_rd_en     = 1'b0;
        o_rd_addr   = '0;
        i_req.ready = (r_state == S_IDLE);
        o_res_valid = (r_state == S_DONE);

        unique case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_new.pri     = i_req.priority_req;
                    n_new.payload = i_req.payload;
                    n_res         = '0;
                    n_res.entry_count = CNT_W'(r_count);
                    if (i_req.opcode == OP_INSERT) begin
                        if (r_count >= CW'(CAPACITY)) begin
                            n_res.status = ST_FULL;
                            n_state      = S_DONE;
                        end else if (r_count == '0) begin
                            // empty queue: store at the head directly
                            o_wr_en           = 1'b1;
                            o_wr_data.pri     = i_req.priority_req;
                            o_wr_data.payload = i_req.payload;
                            n_count           = count_inc;
                            n_res.status      = ST_OK;
                            n_res.entry_count = CNT_W'(count_inc);
                            n_state           = S_DONE;
                        end else begin
                            // scan from the tail toward the head
                            o_rd_en   = 1'b1;
                            o_rd_addr = AW'(r_count - 1'b1);
                            n_k       = AW'(r_count - 1'b1);
                            n_state   = S_SCAN;
                        end
                    end else begin
                        if (32'(i_req.position) >= 32'(r_count)) begin
                            n_res.status = ST_RANGE;
                            n_state      = S_DONE;
                        end else begin
                            o_rd_en   = 1'b1;
                            o_rd_addr = AW'(i_req.position);
                            n_state   = S_RWAIT;
                        end
                    end
                end
            end
            S_RWAIT: begin
                n_res.read_payload  = i_rd_data.payload;
                n_res.read_priority = i_rd_data.pri;
                n_res.status        = ST_OK;
                n_state             = S_DONE;
            end
            S_SCAN: begin
                o_wr_en   = 1'b1;
                o_wr_addr = AW'(r_k + 1'b1);
                if (i_rd_data.pri >= r_new.pri) begin
                    // shift this entry up one slot
                    o_wr_data = i_rd_data;
                    if (r_k == '0) begin
                        n_state = S_PUT;
                    end else begin
                        o_rd_en   = 1'b1;
                        o_rd_addr = AW'(r_k - 1'b1);
                        n_k       = AW'(r_k - 1'b1);
                    end
                end else begin
                    o_wr_data         = r_new;
                    n_count           = count_inc;
                    n_res.status      = ST_OK;
                    n_res.entry_count = CNT_W'(count_inc);
                    n_state           = S_DONE;
                end
            end
            S_PUT: begin
                o_wr_en           = 1'b1;
                o_wr_addr         = '0;
                o_wr_data         = r_new;
                n_count           = count_inc;
                n_res.status      = ST_OK;
                n_res.entry_count = CNT_W'(count_inc);
                n_state           = S_DONE;
            end
            S_DONE: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_res = r_res;

endmodule

### rtl/sipq_checker.sv
module sipq_checker #(
    parameter int CAPACITY = 16
) (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_out_valid,
    input logic                           i_out_ready,
    input logic [sipq_pkg::PAY_W-1:0]     i_read_payload,
    input logic [sipq_pkg::PRI_W-1:0]     i_read_priority,
    input logic [sipq_pkg::CNT_W-1:0]     i_entry_count,
    input logic [sipq_pkg::ST_W-1:0]      i_status
);
    import sipq_pkg::*;

    a_no_data_on_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && (i_status == ST_FULL || i_status == ST_RANGE))
        |-> (i_read_payload == '0 && i_read_priority == '0))
        else $error("error result carries entry data");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_status == ST_OK || i_status == ST_FULL || i_status == ST_RANGE))
        else $error("undefined status code");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_status == ST_FULL) |-> (i_entry_count == CNT_W'(CAPACITY)))
        else $error("full status with count below capacity");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready)
        |=> (i_out_valid && $stable(i_read_payload) && $stable(i_read_priority)
             && $stable(i_entry_count) && $stable(i_status)))
        else $error("stalled result changed");

endmodule

bind sorted_insert_priority_queue sipq_checker #(
    .CAPACITY (CAPACITY)
) u_sipq_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_out_valid     (o_res.valid),
    .i_out_ready     (o_res.ready),
    .i_read_payload  (o_res.read_payload),
    .i_read_priority (o_res.read_priority),
    .i_entry_count   (o_res.entry_count),
    .i_status        (o_res.status)
);
